// File: rtl/debounced_digit_counter_matrix_core_macros.svh
// Assertion macros shared by the digit counter RTL.
`ifndef DEBOUNCED_DIGIT_COUNTER_MATRIX_CORE_MACROS_SVH
`define DEBOUNCED_DIGIT_COUNTER_MATRIX_CORE_MACROS_SVH

// Clocked check, masked while reset is high
`define DDCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked check that also holds during reset
`define DDCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// File: rtl/ddcm_pkg.sv
// Types, constants and the digit font for the debounced digit counter.
package ddcm_pkg;

   localparam int PixelCount = 25;
   localparam int DigitCount = 10;
   localparam int PixIdxW    = 5;
   localparam int DigitW     = 4;
   localparam int ColorW     = 24;
   localparam int TimeW      = 32;
   localparam int LevelW     = 8;
   localparam int CsrIdxW    = 2;
   localparam int QueueDepth = 2;

   localparam logic [TimeW-1:0]  DebounceReset = 32'd300000;
   localparam logic [LevelW-1:0] RedReset      = 8'd50;
   localparam logic [LevelW-1:0] GreenReset    = 8'd0;
   localparam logic [LevelW-1:0] BlueReset     = 8'd0;

   // Input opcodes; the fourth code is ignored like a rejected press
   typedef enum logic [1:0] {
      OP_UP     = 2'd0,
      OP_DOWN   = 2'd1,
      OP_SHOW   = 2'd2,
      OP_IGNORE = 2'd3
   } opcode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_RED      = 2'd1,
      CSR_GREEN    = 2'd2,
      CSR_BLUE     = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_PRESS = 1'b0,
      CMD_SHOW  = 1'b1
   } cmd_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_SHOW = 1'b1
   } back_state_type;

   // One classified item in the queue
   typedef struct packed {
      cmd_type           cmd;
      logic [DigitW-1:0] digit;
      logic              accepted;
   } queue_entry_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Font row for a digit, pixel 0 at the left of the literal
   function automatic logic [0:PixelCount-1] font_row(input logic [DigitW-1:0] digit);
      logic [0:PixelCount-1] row;
      row = '0;
      unique case (digit)
         4'd0:    row = 25'b11111_10001_10001_10001_11111;
         4'd1:    row = 25'b01110_00100_00100_01100_00100;
         4'd2:    row = 25'b11111_10000_11111_00001_11111;
         4'd3:    row = 25'b11111_00001_11111_00001_11111;
         4'd4:    row = 25'b10000_00001_11111_10001_10001;
         4'd5:    row = 25'b11111_00001_11111_10000_11111;
         4'd6:    row = 25'b11111_10001_11111_10000_11111;
         4'd7:    row = 25'b00001_01000_00100_00010_11111;
         4'd8:    row = 25'b11111_10001_11111_10001_11111;
         4'd9:    row = 25'b11111_00001_11111_10001_11111;
         default: row = '0;
      endcase
      return row;
   endfunction

endpackage

// File: rtl/debounced_digit_counter_matrix_core.sv
// Top level of the debounced digit counter with 5x5 pixel digit output.
//
// Input channel req_*: one item per handshake, opcode up press, down press,
// show, or an ignored code, with a microsecond timestamp. Output channel
// rsp_*: a press (or ignored code) gives one status item with last set;
// a show gives 25 pixel items in chain order, last on pixel 24.
// Configuration: csr_wr_en with csr_index and csr_wdata writes debounce
// time and the red, green and blue levels of lit pixels.
// The first result of an item passes through the command queue and then
// the output register. The back end emits one pixel per cycle from the
// font table while rsp_ready does not stall it. The front end
// takes items while the back end is busy until the command queue is full.
// Reset clears the digit and both press times to zero, empties the queue,
// drops any pending result and loads the default register values.
// A stall on rsp_ready holds the output register; the back end waits, the
// queue fills, and then req_ready falls.
module debounced_digit_counter_matrix_core #(
   parameter int QUEUE_DEPTH = ddcm_pkg::QueueDepth
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [ddcm_pkg::TimeW-1:0]         req_time_us,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ddcm_pkg::ColorW-1:0]        rsp_pixel_color,
   output logic [ddcm_pkg::PixIdxW-1:0]       rsp_pixel_index,
   output logic                               rsp_last,
   output logic [ddcm_pkg::DigitW-1:0]        rsp_digit,
   output logic                               rsp_accepted,
   input  logic                               csr_wr_en,
   input  logic [ddcm_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [ddcm_pkg::TimeW-1:0]         csr_wdata
);

   logic [ddcm_pkg::TimeW-1:0]  debounce_ff;
   logic [ddcm_pkg::LevelW-1:0] red_ff, green_ff, blue_ff;
   logic [ddcm_pkg::ColorW-1:0] lit_color;

   ddcm_pkg::queue_status_type queue_status;
   ddcm_pkg::queue_entry_type  push_entry, head_entry;
   logic                       queue_push, queue_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= ddcm_pkg::DebounceReset;
         red_ff      <= ddcm_pkg::RedReset;
         green_ff    <= ddcm_pkg::GreenReset;
         blue_ff     <= ddcm_pkg::BlueReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ddcm_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            ddcm_pkg::CSR_RED:      red_ff      <= csr_wdata[ddcm_pkg::LevelW-1:0];
            ddcm_pkg::CSR_GREEN:    green_ff    <= csr_wdata[ddcm_pkg::LevelW-1:0];
            ddcm_pkg::CSR_BLUE:     blue_ff     <= csr_wdata[ddcm_pkg::LevelW-1:0];
            default:                debounce_ff <= debounce_ff;
         endcase
      end
   end

   // GRB order for the pixel chain
   assign lit_color = {green_ff, red_ff, blue_ff};

   ddcm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_time_us  (req_time_us),
      .debounce_us  (debounce_ff),
      .queue_status (queue_status),
      .queue_push   (queue_push),
      .queue_entry  (push_entry)
   );

   ddcm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   ddcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head_entry      (head_entry),
      .queue_pop       (queue_pop),
      .lit_color       (lit_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_last        (rsp_last),
      .rsp_digit       (rsp_digit),
      .rsp_accepted    (rsp_accepted)
   );

endmodule

// File: rtl/ddcm_front.sv
// Front end: takes items, debounces presses, keeps the digit, queues commands.
`include "debounced_digit_counter_matrix_core_macros.svh"

module ddcm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [ddcm_pkg::TimeW-1:0]        req_time_us,
   input  logic [ddcm_pkg::TimeW-1:0]        debounce_us,
   input  ddcm_pkg::queue_status_type        queue_status,
   output logic                              queue_push,
   output ddcm_pkg::queue_entry_type         queue_entry
);

   logic [ddcm_pkg::DigitW-1:0] digit_ff, digit_in;
   logic [ddcm_pkg::TimeW-1:0]  up_last_ff, up_last_in;
   logic [ddcm_pkg::TimeW-1:0]  down_last_ff, down_last_in;
   logic [ddcm_pkg::TimeW-1:0]  up_elapsed, down_elapsed;
   logic                        up_open, down_open;
   logic                        accept;
   logic                        press_ok;

   assign req_ready  = !queue_status.full;
   assign accept     = req_valid && req_ready;
   assign queue_push = accept;

   // Wrapping elapsed time per button, strict compare
   assign up_elapsed   = req_time_us - up_last_ff;
   assign down_elapsed = req_time_us - down_last_ff;
   assign up_open      = up_elapsed > debounce_us;
   assign down_open    = down_elapsed > debounce_us;

   // Digit and press-time updates
   always_comb begin
      digit_in     = digit_ff;
      up_last_in   = up_last_ff;
      down_last_in = down_last_ff;
      press_ok     = 1'b0;
      if (accept) begin
         if (req_opcode == ddcm_pkg::OP_UP && up_open) begin
            press_ok   = 1'b1;
            up_last_in = req_time_us;
            digit_in   = (digit_ff == ddcm_pkg::DigitW'(ddcm_pkg::DigitCount - 1))
                         ? '0 : digit_ff + 1'b1;
         end else if (req_opcode == ddcm_pkg::OP_DOWN && down_open) begin
            press_ok     = 1'b1;
            down_last_in = req_time_us;
            digit_in     = (digit_ff == '0)
                           ? ddcm_pkg::DigitW'(ddcm_pkg::DigitCount - 1) : digit_ff - 1'b1;
         end
      end
   end

   // Command handed to the back end
   always_comb begin
      queue_entry.cmd      = (req_opcode == ddcm_pkg::OP_SHOW) ? ddcm_pkg::CMD_SHOW
                                                               : ddcm_pkg::CMD_PRESS;
      queue_entry.digit    = digit_in;
      queue_entry.accepted = press_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff     <= '0;
         up_last_ff   <= '0;
         down_last_ff <= '0;
      end else begin
         digit_ff     <= digit_in;
         up_last_ff   <= up_last_in;
         down_last_ff <= down_last_in;
      end
   end

   `DDCM_ASSERT(a_digit_range, clock, reset,
      digit_ff <= ddcm_pkg::DigitW'(ddcm_pkg::DigitCount - 1), "digit out of range")

endmodule

// File: rtl/ddcm_queue.sv
// Small command queue between the front and back ends.
`include "debounced_digit_counter_matrix_core_macros.svh"

module ddcm_queue #(
   parameter int DEPTH = ddcm_pkg::QueueDepth   // two or more
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ddcm_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output ddcm_pkg::queue_entry_type  head_entry,
   output ddcm_pkg::queue_status_type status
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   ddcm_pkg::queue_entry_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry   = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `DDCM_ASSERT(a_no_overflow, clock, reset, push |-> !status.full, "push into full queue")
   `DDCM_ASSERT(a_no_underflow, clock, reset, pop |-> !status.empty, "pop from empty queue")
   `DDCM_ASSERT(a_count_bound, clock, reset, count_ff <= CntW'(DEPTH), "fill count too high")

endmodule

// File: rtl/ddcm_back.sv
// Back end: turns queued commands into status or pixel items on the output.
`include "debounced_digit_counter_matrix_core_macros.svh"

module ddcm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  ddcm_pkg::queue_status_type         queue_status,
   input  ddcm_pkg::queue_entry_type          head_entry,
   output logic                               queue_pop,
   input  logic [ddcm_pkg::ColorW-1:0]        lit_color,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ddcm_pkg::ColorW-1:0]        rsp_pixel_color,
   output logic [ddcm_pkg::PixIdxW-1:0]       rsp_pixel_index,
   output logic                               rsp_last,
   output logic [ddcm_pkg::DigitW-1:0]        rsp_digit,
   output logic                               rsp_accepted
);

   localparam logic [ddcm_pkg::PixIdxW-1:0] LastPix =
      ddcm_pkg::PixIdxW'(ddcm_pkg::PixelCount - 1);

   ddcm_pkg::back_state_type state_ff, state_in;
   logic [ddcm_pkg::PixIdxW-1:0] pix_ff, pix_in;
   logic [ddcm_pkg::DigitW-1:0]  show_digit_ff, show_digit_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ddcm_pkg::ColorW-1:0]  color_ff, color_in;
   logic [ddcm_pkg::PixIdxW-1:0] index_ff, index_in;
   logic                         last_ff, last_in;
   logic [ddcm_pkg::DigitW-1:0]  digit_ff, digit_in;
   logic                         acc_ff, acc_in;

   logic                         slot_free;
   logic                         load;
   logic [0:ddcm_pkg::PixelCount-1] show_row, head_row;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign show_row  = ddcm_pkg::font_row(show_digit_ff);
   assign head_row  = ddcm_pkg::font_row(head_entry.digit);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddcm_pkg::BACK_IDLE: begin
            if (!queue_status.empty && slot_free && head_entry.cmd == ddcm_pkg::CMD_SHOW) begin
               state_in = ddcm_pkg::BACK_SHOW;
            end
         end
         ddcm_pkg::BACK_SHOW: begin
            if (slot_free && pix_ff == LastPix) begin
               state_in = ddcm_pkg::BACK_IDLE;
            end
         end
         default: state_in = ddcm_pkg::BACK_IDLE;
      endcase
   end

   // Pop, output load and pixel count
   always_comb begin
      queue_pop     = 1'b0;
      load          = 1'b0;
      pix_in        = pix_ff;
      show_digit_in = show_digit_ff;
      color_in      = color_ff;
      index_in      = index_ff;
      last_in       = last_ff;
      digit_in      = digit_ff;
      acc_in        = acc_ff;
      unique case (state_ff)
         ddcm_pkg::BACK_IDLE: begin
            if (!queue_status.empty && slot_free) begin
               queue_pop = 1'b1;
               load      = 1'b1;
               digit_in  = head_entry.digit;
               index_in  = '0;
               if (head_entry.cmd == ddcm_pkg::CMD_SHOW) begin
                  // first pixel goes out straight away
                  color_in      = head_row[0] ? lit_color : '0;
                  last_in       = 1'b0;
                  acc_in        = 1'b0;
                  pix_in        = ddcm_pkg::PixIdxW'(1);
                  show_digit_in = head_entry.digit;
               end else begin
                  color_in = '0;
                  last_in  = 1'b1;
                  acc_in   = head_entry.accepted;
               end
            end
         end
         ddcm_pkg::BACK_SHOW: begin
            if (slot_free) begin
               load     = 1'b1;
               color_in = show_row[pix_ff] ? lit_color : '0;
               index_in = pix_ff;
               last_in  = (pix_ff == LastPix);
               digit_in = show_digit_ff;
               acc_in   = 1'b0;
               pix_in   = pix_ff + 1'b1;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddcm_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and counters, no reset
   always_ff @(posedge clock) begin
      pix_ff        <= pix_in;
      show_digit_ff <= show_digit_in;
      color_ff      <= color_in;
      index_ff      <= index_in;
      last_ff       <= last_in;
      digit_ff      <= digit_in;
      acc_ff        <= acc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_last        = last_ff;
   assign rsp_digit       = digit_ff;
   assign rsp_accepted    = acc_ff;

   `DDCM_ASSERT(a_no_pop_mid_show, clock, reset,
      state_ff == ddcm_pkg::BACK_SHOW |-> !queue_pop, "queue popped during a show run")
   `DDCM_ASSERT(a_show_ends, clock, reset,
      (state_ff == ddcm_pkg::BACK_SHOW && load && pix_ff == LastPix)
      |=> (state_ff == ddcm_pkg::BACK_IDLE && rsp_last), "show run did not end on last pixel")

endmodule
